// ----- rtl/jsu_pkg.sv -----
package jsu_pkg;

  typedef enum logic [6:0] {
    PH_NORMAL  = 7'b0000001,
    PH_ESC     = 7'b0000010,
    PH_HEX     = 7'b0000100,
    PH_WANT_BS = 7'b0001000,
    PH_WANT_U  = 7'b0010000,
    PH_TRL     = 7'b0100000,
    PH_DISCARD = 7'b1000000
  } phase_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_HEX    = 3'd1;
  localparam logic [2:0] ST_TRUNC      = 3'd2;
  localparam logic [2:0] ST_LONE_TRAIL = 3'd3;
  localparam logic [2:0] ST_NO_U       = 3'd4;
  localparam logic [2:0] ST_BAD_TRAIL  = 3'd5;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [5:0] LEAD_TOP  = 6'b110110;
  localparam logic [5:0] TRAIL_TOP = 6'b110111;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;
  } utf8_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      cnt_m1;
    logic            data_valid;
    logic            str_last;
    logic [2:0]      status;
  } bundle_t;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.bytes = '0;
    if (cp < 21'h80) begin
      u.cnt_m1   = 2'd0;
      u.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      u.cnt_m1   = 2'd1;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      u.cnt_m1   = 2'd2;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.cnt_m1   = 2'd3;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// ----- rtl/json_string_unescape_utf8_unit.sv -----
// Streaming JSON string-body unescaper with UTF-8 output.
// The slave channel takes one raw byte of the string body per item in
// s_axis_tdata, with s_axis_tlast on the final byte of the string. The
// master channel gives one unescaped byte per item; a \u escape yields one
// to three items, a surrogate pair four. An escape in progress yields none.
// The last item of each string carries m_axis_tlast and the final status
// (0 ok, 1 bad hex, 2 truncated escape, 3 lone trail, 4 missing \u after
// a lead, 5 bad trail); if that byte yields no data, a status-only item
// with m_axis_tuser low is sent. After an error, bytes are consumed
// silently until the end of the string.
// Two bundle registers, the core's and then the serializer's, lie between
// acceptance and the first output item and decouple the channels, so
// input keeps flowing while the receiver holds m_axis_tready low, until
// both are full. While m_axis_tready is high, an item is accepted every
// cycle while each yields at most one output byte, and the single-byte
// output port sets the rate for multi-byte sequences, one output item per
// cycle. Synchronous reset clears escape state, empties both registers.
module json_string_unescape_utf8_unit import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [8] run_last, [11:9] status
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // [0] byte_valid
);

  logic    bnd_valid;
  logic    bnd_take;
  bundle_t bnd;

  jsu_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .is_last   (s_axis_tlast),
    .bnd_valid (bnd_valid),
    .bnd_take  (bnd_take),
    .bnd       (bnd)
  );

  jsu_ser u_ser (
    .clk           (clk),
    .rst           (rst),
    .bnd_valid     (bnd_valid),
    .bnd_take      (bnd_take),
    .bnd           (bnd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- rtl/jsu_core.sv -----
module jsu_core import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  output logic       bnd_valid,
  input  logic       bnd_take,
  output bundle_t    bnd
);

  phase_t      phase, phase_next;
  logic [1:0]  dcnt, dcnt_next;
  logic [15:0] code_accum, code_next;
  logic [9:0]  lead_bits, lead_next;
  logic [2:0]  sticky, sticky_next;
  logic [2:0]  err;
  logic [4:0]  hx;
  logic [15:0] shifted;
  logic        has_out;
  utf8_t       enc;
  bundle_t     bnd_next;
  logic        accept;

  assign in_ready = !bnd_valid || bnd_take;
  assign accept   = in_valid && in_ready;
  assign hx       = hex_digit(in_byte);
  assign shifted  = {code_accum[11:0], hx[3:0]};

  always_comb begin
    phase_next  = phase;
    dcnt_next   = dcnt;
    code_next   = code_accum;
    lead_next   = lead_bits;
    sticky_next = sticky;
    err         = ST_OK;
    has_out     = 1'b0;
    enc.bytes   = '0;
    enc.cnt_m1  = 2'd0;
    unique case (phase)
      PH_ESC: begin
        phase_next = PH_NORMAL;
        has_out    = 1'b1;
        unique case (in_byte)
          CH_B: enc.bytes[0] = 8'h08;
          CH_F: enc.bytes[0] = 8'h0C;
          CH_N: enc.bytes[0] = 8'h0A;
          CH_R: enc.bytes[0] = 8'h0D;
          CH_T: enc.bytes[0] = 8'h09;
          CH_U: begin
            has_out    = 1'b0;
            phase_next = PH_HEX;
            dcnt_next  = 2'd0;
            code_next  = '0;
          end
          default: enc.bytes[0] = in_byte;
        endcase
      end
      PH_HEX: begin
        if (!hx[4]) begin
          err = ST_BAD_HEX;
        end else begin
          code_next = shifted;
          if (dcnt != 2'd3) begin
            dcnt_next = dcnt + 2'd1;
          end else if (shifted[15:10] == TRAIL_TOP) begin
            err = ST_LONE_TRAIL;
          end else if (shifted[15:10] == LEAD_TOP) begin
            lead_next  = shifted[9:0];
            phase_next = PH_WANT_BS;
          end else begin
            has_out    = 1'b1;
            enc        = utf8_encode({5'd0, shifted});
            phase_next = PH_NORMAL;
          end
        end
      end
      PH_WANT_BS: begin
        if (in_byte == CH_BACKSLASH) phase_next = PH_WANT_U;
        else err = ST_NO_U;
      end
      PH_WANT_U: begin
        if (in_byte == CH_U) begin
          phase_next = PH_TRL;
          dcnt_next  = 2'd0;
          code_next  = '0;
        end else begin
          err = ST_NO_U;
        end
      end
      PH_TRL: begin
        if (!hx[4]) begin
          err = ST_BAD_HEX;
        end else begin
          code_next = shifted;
          if (dcnt != 2'd3) begin
            dcnt_next = dcnt + 2'd1;
          end else if (shifted[15:10] != TRAIL_TOP) begin
            err = ST_BAD_TRAIL;
          end else begin
            has_out    = 1'b1;
            enc        = utf8_encode(SUPP_BASE + {1'b0, lead_bits, shifted[9:0]});
            phase_next = PH_NORMAL;
          end
        end
      end
      PH_DISCARD: begin
      end
      default: begin
        if (in_byte == CH_BACKSLASH) begin
          phase_next = PH_ESC;
        end else begin
          has_out    = 1'b1;
          enc.bytes[0] = in_byte;
          phase_next = PH_NORMAL;
        end
      end
    endcase

    if (err != ST_OK) begin
      phase_next = PH_DISCARD;
      if (sticky == ST_OK) sticky_next = err;
    end
    if (is_last && sticky_next == ST_OK &&
        (phase_next == PH_HEX || phase_next == PH_WANT_BS ||
         phase_next == PH_WANT_U || phase_next == PH_TRL)) begin
      sticky_next = ST_TRUNC;
    end

    bnd_next.bytes      = has_out ? enc.bytes : '0;
    bnd_next.cnt_m1     = has_out ? enc.cnt_m1 : 2'd0;
    bnd_next.data_valid = has_out;
    bnd_next.str_last   = is_last;
    bnd_next.status     = sticky_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_NORMAL;
      dcnt       <= '0;
      code_accum <= '0;
      lead_bits  <= '0;
      sticky     <= ST_OK;
      bnd_valid  <= 1'b0;
    end else begin
      if (accept) begin
        bnd_valid <= has_out || is_last;
        if (is_last) begin
          phase      <= PH_NORMAL;
          dcnt       <= '0;
          code_accum <= '0;
          lead_bits  <= '0;
          sticky     <= ST_OK;
        end else begin
          phase      <= phase_next;
          dcnt       <= dcnt_next;
          code_accum <= code_next;
          lead_bits  <= lead_next;
          sticky     <= sticky_next;
        end
      end else if (bnd_take) begin
        bnd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) bnd <= bnd_next;
  end

endmodule

// ----- rtl/jsu_ser.sv -----
module jsu_ser import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        bnd_valid,
  output logic        bnd_take,
  input  bundle_t     bnd,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tuser
);

  bundle_t    cur;
  logic       busy;
  logic [1:0] idx;
  logic       at_end;
  logic       done;

  assign at_end   = idx == cur.cnt_m1;
  assign done     = busy && m_axis_tready && at_end;
  assign bnd_take = bnd_valid && (!busy || done);

  assign m_axis_tvalid = busy;
  assign m_axis_tlast  = cur.str_last && at_end;
  assign m_axis_tuser  = cur.data_valid;
  assign m_axis_tdata  = {4'd0, (m_axis_tlast ? cur.status : ST_OK), at_end, cur.bytes[idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (bnd_take) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (done) begin
        busy <= 1'b0;
        idx  <= '0;
      end else if (busy && m_axis_tready) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bnd_take) cur <= bnd;
  end

endmodule

// ----- sim/json_string_unescape_utf8_unit_test.sv -----
module json_string_unescape_utf8_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
    logic [2:0] status;
  } unescaped_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  int idle_pct = 26;
  int errors = 0;
  int cycle_count = 0;

  unescaped_t expected_out[$];
  logic [7:0] step_bytes[$];
  logic [7:0] raw_run[$];

  phase_t     ph = PH_NORMAL;
  logic [1:0] hex_idx;
  logic [15:0] code_acc;
  logic [9:0] lead_low;
  logic [2:0] sticky;

  json_string_unescape_utf8_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int hex_val(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic void clear_state();
    ph       = PH_NORMAL;
    hex_idx  = 2'd0;
    code_acc = 16'h0000;
    lead_low = 10'h000;
    sticky   = ST_OK;
  endfunction

  function automatic void raise_fault(logic [2:0] code);
    if (sticky == ST_OK) sticky = code;
    ph = PH_DISCARD;
  endfunction

  function automatic void emit_code_point(logic [20:0] cp);
    if (cp < 21'h80) begin
      step_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      step_bytes.push_back(8'hC0 | 8'(cp >> 6));
      step_bytes.push_back(8'h80 | 8'(cp & 21'h3F));
    end else if (cp < 21'h10000) begin
      step_bytes.push_back(8'hE0 | 8'(cp >> 12));
      step_bytes.push_back(8'h80 | 8'((cp >> 6) & 21'h3F));
      step_bytes.push_back(8'h80 | 8'(cp & 21'h3F));
    end else begin
      step_bytes.push_back(8'hF0 | 8'((cp >> 18) & 21'h7));
      step_bytes.push_back(8'h80 | 8'((cp >> 12) & 21'h3F));
      step_bytes.push_back(8'h80 | 8'((cp >> 6) & 21'h3F));
      step_bytes.push_back(8'h80 | 8'(cp & 21'h3F));
    end
  endfunction

  function automatic void unescape_byte(logic [7:0] b, logic last);
    int h;
    int n;
    unescaped_t r;
    step_bytes.delete();
    h = hex_val(b);
    if (sticky != ST_OK) ph = PH_DISCARD;
    case (ph)
      PH_NORMAL: begin
        if (b == CH_BACKSLASH) ph = PH_ESC;
        else step_bytes.push_back(b);
      end
      PH_ESC: begin
        ph = PH_NORMAL;
        case (b)
          CH_B: step_bytes.push_back(8'h08);
          CH_F: step_bytes.push_back(8'h0C);
          CH_N: step_bytes.push_back(8'h0A);
          CH_R: step_bytes.push_back(8'h0D);
          CH_T: step_bytes.push_back(8'h09);
          CH_U: begin
            ph       = PH_HEX;
            hex_idx  = 2'd0;
            code_acc = 16'h0000;
          end
          default: step_bytes.push_back(b);
        endcase
      end
      PH_HEX: begin
        if (h < 0) begin
          raise_fault(ST_BAD_HEX);
        end else begin
          code_acc = {code_acc[11:0], 4'(h)};
          if (hex_idx != 2'd3) begin
            hex_idx++;
          end else if (code_acc >= 16'hDC00 && code_acc <= 16'hDFFF) begin
            raise_fault(ST_LONE_TRAIL);
          end else if (code_acc >= 16'hD800 && code_acc <= 16'hDBFF) begin
            lead_low = code_acc[9:0];
            ph       = PH_WANT_BS;
          end else begin
            emit_code_point({5'd0, code_acc});
            ph = PH_NORMAL;
          end
        end
      end
      PH_WANT_BS: begin
        if (b == CH_BACKSLASH) ph = PH_WANT_U;
        else raise_fault(ST_NO_U);
      end
      PH_WANT_U: begin
        if (b == CH_U) begin
          ph       = PH_TRL;
          hex_idx  = 2'd0;
          code_acc = 16'h0000;
        end else begin
          raise_fault(ST_NO_U);
        end
      end
      PH_TRL: begin
        if (h < 0) begin
          raise_fault(ST_BAD_HEX);
        end else begin
          code_acc = {code_acc[11:0], 4'(h)};
          if (hex_idx != 2'd3) begin
            hex_idx++;
          end else if (code_acc < 16'hDC00 || code_acc > 16'hDFFF) begin
            raise_fault(ST_BAD_TRAIL);
          end else begin
            emit_code_point(21'h10000 + {1'b0, lead_low, code_acc[9:0]});
            ph = PH_NORMAL;
          end
        end
      end
      default: begin
      end
    endcase

    if (last && (ph inside {PH_HEX, PH_WANT_BS, PH_WANT_U, PH_TRL})) raise_fault(ST_TRUNC);

    n = step_bytes.size();
    if (last && n == 0) begin
      r            = '0;
      r.run_last   = 1'b1;
      r.string_end = 1'b1;
      r.status     = sticky;
      expected_out.push_back(r);
    end
    for (int i = 0; i < n; i++) begin
      r            = '0;
      r.out_byte   = step_bytes[i];
      r.byte_valid = 1'b1;
      r.run_last   = (i == n - 1);
      if (last && i == n - 1) begin
        r.string_end = 1'b1;
        r.status     = sticky;
      end
      expected_out.push_back(r);
    end
    if (last) clear_state();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    unescape_byte(b, last);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin : check_results
    unescaped_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_out.size() == 0) begin
        $error("unexpected item: out_byte %h", m_axis_tdata[7:0]);
        errors++;
      end else begin
        want = expected_out.pop_front();
        if (m_axis_tdata[7:0] !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, m_axis_tdata[7:0]);
          errors++;
        end
        if (m_axis_tuser !== want.byte_valid) begin
          $error("byte_valid: expected %b, actual %b", want.byte_valid, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[8] !== want.run_last) begin
          $error("run_last: expected %b, actual %b", want.run_last, m_axis_tdata[8]);
          errors++;
        end
        if (m_axis_tlast !== want.string_end) begin
          $error("string_end: expected %b, actual %b", want.string_end, m_axis_tlast);
          errors++;
        end
        if (m_axis_tdata[11:9] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tdata[11:9]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("json_string_unescape_utf8_unit: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic void push_u_escape(logic [15:0] code);
    raw_run.push_back(CH_BACKSLASH);
    raw_run.push_back(CH_U);
    raw_run.push_back(hex_char(code[15:12]));
    raw_run.push_back(hex_char(code[11:8]));
    raw_run.push_back(hex_char(code[7:4]));
    raw_run.push_back(hex_char(code[3:0]));
  endfunction

  function automatic logic [7:0] byte_other_than(logic [7:0] avoid, logic avoid_hex);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (avoid_hex ? (hex_val(b) >= 0) : (b == avoid));
    return b;
  endfunction

  function automatic void add_random_token();
    int r;
    int k;
    logic [15:0] c;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      raw_run.push_back(8'($urandom_range(0, 255)));
    end else if (r < 55) begin
      raw_run.push_back(CH_BACKSLASH);
      k = $urandom_range(0, 8);
      case (k)
        0: raw_run.push_back(8'h22);
        1: raw_run.push_back(CH_BACKSLASH);
        2: raw_run.push_back(8'h2F);
        3: raw_run.push_back(CH_B);
        4: raw_run.push_back(CH_F);
        5: raw_run.push_back(CH_N);
        6: raw_run.push_back(CH_R);
        7: raw_run.push_back(CH_T);
        default: raw_run.push_back(8'($urandom_range(0, 255)));
      endcase
    end else if (r < 75) begin
      k = $urandom_range(0, 2);
      if (k == 0) begin
        c = 16'($urandom_range(0, 'h7F));
      end else if (k == 1) begin
        c = 16'($urandom_range('h80, 'h7FF));
      end else begin
        c = 16'($urandom_range('h800, 'hF7FF));
        if (c >= 16'hD800) c = c + 16'h0800;
      end
      push_u_escape(c);
    end else if (r < 87) begin
      push_u_escape(16'($urandom_range('hD800, 'hDBFF)));
      push_u_escape(16'($urandom_range('hDC00, 'hDFFF)));
    end else begin
      k = $urandom_range(0, 4);
      case (k)
        0: begin
          raw_run.push_back(CH_BACKSLASH);
          raw_run.push_back(CH_U);
          repeat ($urandom_range(0, 3)) raw_run.push_back(hex_char(4'($urandom)));
          raw_run.push_back(byte_other_than(8'h00, 1'b1));
        end
        1: push_u_escape(16'($urandom_range('hDC00, 'hDFFF)));
        2: begin
          push_u_escape(16'($urandom_range('hD800, 'hDBFF)));
          raw_run.push_back(byte_other_than(CH_BACKSLASH, 1'b0));
        end
        3: begin
          push_u_escape(16'($urandom_range('hD800, 'hDBFF)));
          raw_run.push_back(CH_BACKSLASH);
          raw_run.push_back(byte_other_than(CH_U, 1'b0));
        end
        default: begin
          push_u_escape(16'($urandom_range('hD800, 'hDBFF)));
          do c = 16'($urandom); while (c >= 16'hDC00 && c <= 16'hDFFF);
          push_u_escape(c);
        end
      endcase
    end
  endfunction

  task automatic test_plain_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_short_escapes();
    send_text("\\b\\t\\q");
  endtask

  task automatic test_unicode_escapes();
    send_text("\\u0000\\ud83D\\uDE00");
  endtask

  task automatic test_faults();
    send_text("\\");
    send_text("\\uDC0");
    send_text("\\uGx");
  endtask

  task automatic test_random_strings();
    int sent;
    int cut;
    sent = 0;
    while (sent < 190) begin
      idle_pct = (sent >= 60 && sent < 130) ? 0 : 26;
      raw_run.delete();
      repeat ($urandom_range(1, 6)) add_random_token();
      if ($urandom_range(0, 9) == 0) begin
        cut = $urandom_range(1, 11);
        push_u_escape(16'($urandom_range('hD800, 'hDBFF)));
        push_u_escape(16'($urandom_range('hDC00, 'hDFFF)));
        repeat (12 - cut) void'(raw_run.pop_back());
      end
      foreach (raw_run[i]) send_byte(raw_run[i], i == raw_run.size() - 1);
      sent += raw_run.size();
    end
    idle_pct = 26;
  endtask

  initial begin
    clear_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_plain_bytes();
    test_short_escapes();
    test_unicode_escapes();
    test_faults();
    test_random_strings();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("json_string_unescape_utf8_unit: match");
    end else begin
      $display("json_string_unescape_utf8_unit: mismatch");
    end
    $finish;
  end

endmodule
